### rtl/core/multimode_pid_controller_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property forms for the controller checkers, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTIMODE_PID_CONTROLLER_ASSERT_SVH
`define MULTIMODE_PID_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define MPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mpid_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, mode codes, sequencer states and saturation helpers.
// ----------------------------------------------------------------------------
package mpid_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned LIM_W         = 31;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned PROD_W        = 64;
  localparam int unsigned WIDE_W        = 48;
  localparam int unsigned SUM_W         = 34;
  localparam int unsigned DIV_CNT_W     = 5;

  localparam logic [MODE_W-1:0] MODE_SEP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VARY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRAP = 2'd2;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [LIM_W-1:0] VARY_SCALE_RST = 31'd65536;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP_MODE  = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_OUT_LIMIT  = 3'd4,
    REG_INT_LIMIT  = 3'd5,
    REG_VARY_SCALE = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_WRAP,
    S_ABS,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_MUL_S,
    S_DIV_GO,
    S_DIV_WAIT,
    S_INTEG,
    S_TOTAL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic negate;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = $signed(v[DATA_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [PROD_W-1:0] v,
                                                         input logic [LIM_W-1:0] lim);
    logic signed [PROD_W-1:0] lim_s;
    logic signed [PROD_W-1:0] neg_s;
    logic signed [DATA_W-1:0] r;
    lim_s = $signed({{(PROD_W-LIM_W){1'b0}}, lim});
    neg_s = -lim_s;
    if (v > lim_s) begin
      r = $signed(lim_s[DATA_W-1:0]);
    end else if (v < neg_s) begin
      r = $signed(neg_s[DATA_W-1:0]);
    end else begin
      r = $signed(v[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

### rtl/core/multimode_pid_controller.sv
// Flow: a step item passes the error, wrap, magnitude and four multiply states, then in mode 1
// the divider unless S + |e| is zero, then the integral and total states; a clear goes straight to its result.
// The block takes no new item until the previous one is through; it has one shared 32x32
// multiplier used four times and a 32-step divider.
// A new item is taken while the previous drive still waits at the output.
// Reset: asynchronous, active low; clears state, configuration, drive, loop history and handshakes.
// ----------------------------------------------------------------------------
// Multimode PID controller
// Fixed-point PID with integral separation, variable-speed integral and wrapped
// angle error, built around a shared multiplier and a divider under a sequencer.
// ----------------------------------------------------------------------------
module multimode_pid_controller import mpid_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic signed [DATA_W-1:0] target_i,
  input  logic signed [DATA_W-1:0] measured_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] drive_o
);

  localparam logic signed [WIDE_W-1:0] WrapHalf = 48'sd4096 <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] WrapSpan = 48'sd8192 <<< FRAC_BITS;
  localparam logic [WIDE_W-1:0]        SepLim   = 48'd300 << FRAC_BITS;

  // configuration
  logic [MODE_W-1:0]        loop_mode_q;
  logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [LIM_W-1:0]         out_limit_q, int_limit_q, vary_scale_q;

  // sequencer and state
  state_e                   state_q, state_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q;
  logic signed [DATA_W-1:0] last_error_q, integral_q;

  // datapath
  logic signed [DATA_W-1:0] tgt_q, meas_q;
  logic signed [DATA_W-1:0] e_q, diff_q;
  logic [DATA_W-1:0]        ae_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] pterm_q, step_q, dterm_q, isum_q;
  logic signed [SUM_W-1:0]  total_q;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [DATA_W-1:0] prod_sat;
  logic signed [PROD_W-1:0] prod_mag;
  logic signed [WIDE_W-1:0] e_wide, e_wrap;
  logic [DATA_W:0]          den;
  logic                     den_zero;
  logic                     use_int;
  logic signed [DATA_W-1:0] int_acc;
  logic signed [PROD_W-1:0] total_sum;
  logic                     in_take;
  logic                     fin_write;

  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic signed [DATA_W-1:0] div_quot;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q  <= MODE_SEP;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      out_limit_q  <= '0;
      int_limit_q  <= '0;
      vary_scale_q <= VARY_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOOP_MODE:  loop_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        REG_GAIN_P:     gain_p_q     <= $signed(cfg_wdata_i);
        REG_GAIN_I:     gain_i_q     <= $signed(cfg_wdata_i);
        REG_GAIN_D:     gain_d_q     <= $signed(cfg_wdata_i);
        REG_OUT_LIMIT:  out_limit_q  <= cfg_wdata_i[LIM_W-1:0];
        REG_INT_LIMIT:  int_limit_q  <= cfg_wdata_i[LIM_W-1:0];
        REG_VARY_SCALE: vary_scale_q <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = gain_p_q;
    mul_b = e_q;
    case (state_q)
      S_MUL_I: begin
        mul_a = gain_i_q;
        mul_b = e_q;
      end
      S_MUL_D: begin
        mul_a = gain_d_q;
        mul_b = diff_q;
      end
      S_MUL_S: begin
        mul_a = step_q;
        mul_b = $signed({1'b0, vary_scale_q});
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  // floor shift back to Q format, then saturate
  assign prod_sat = sat32(prod_q >>> FRAC_BITS);
  assign prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;

  assign e_wide = WIDE_W'(e_q);
  always_comb begin
    e_wrap = e_wide;
    if (e_wide > WrapHalf) begin
      e_wrap = e_wide - WrapSpan;
    end else if (e_wide < -WrapHalf) begin
      e_wrap = e_wide + WrapSpan;
    end
  end

  assign den      = {2'b00, vary_scale_q} + {1'b0, ae_q};
  assign den_zero = (den == '0);
  assign use_int  = (loop_mode_q == MODE_VARY) || ({{(WIDE_W-DATA_W){1'b0}}, ae_q} < SepLim);
  assign int_acc  = sat32(PROD_W'(integral_q) + PROD_W'(step_q));
  assign total_sum = PROD_W'(total_q);

  assign in_take   = in_valid_i && in_ready_o;
  assign fin_write = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    div_req.start  = 1'b0;
    div_req.negate = prod_q[PROD_W-1];
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (operation_i == OP_CLEAR) ? S_FIN : S_ERR;
        end
      end
      S_ERR:   state_d = S_WRAP;
      S_WRAP:  state_d = S_ABS;
      S_ABS:   state_d = S_MUL_P;
      S_MUL_P: state_d = S_MUL_I;
      S_MUL_I: state_d = S_MUL_D;
      S_MUL_D: state_d = S_MUL_S;
      S_MUL_S: state_d = (loop_mode_q == MODE_VARY) ? S_DIV_GO : S_INTEG;
      S_DIV_GO: begin
        div_req.start = !den_zero;
        state_d       = den_zero ? S_INTEG : S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = S_INTEG;
        end
      end
      S_INTEG: state_d = S_TOTAL;
      S_TOTAL: state_d = S_FIN;
      S_FIN: begin
        if (fin_write) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      drive_q      <= '0;
      last_error_q <= '0;
      integral_q   <= '0;
    end else begin
      state_q <= state_d;
      if (fin_write) begin
        out_valid_q <= 1'b1;
        drive_q     <= clamp_sym(total_sum, out_limit_q);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_take && operation_i == OP_CLEAR) begin
        last_error_q <= '0;
        integral_q   <= '0;
      end else if (state_q == S_TOTAL) begin
        last_error_q <= e_q;
        integral_q   <= isum_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        tgt_q   <= target_i;
        meas_q  <= measured_i;
        total_q <= '0;
      end
      S_ERR: e_q <= sat32(PROD_W'(tgt_q) - PROD_W'(meas_q));
      S_WRAP: begin
        if (loop_mode_q == MODE_WRAP) begin
          e_q <= sat32(PROD_W'(e_wrap));
        end
      end
      S_ABS: begin
        ae_q   <= e_q[DATA_W-1] ? (~e_q + 1'b1) : e_q;
        diff_q <= sat32(PROD_W'(e_q) - PROD_W'(last_error_q));
      end
      S_MUL_P: prod_q <= mul_p;
      S_MUL_I: begin
        pterm_q <= prod_sat;
        prod_q  <= mul_p;
      end
      S_MUL_D: begin
        step_q <= prod_sat;
        prod_q <= mul_p;
      end
      S_MUL_S: begin
        dterm_q <= prod_sat;
        prod_q  <= mul_p;
      end
      S_DIV_GO: begin
        if (den_zero) begin
          step_q <= '0;
        end
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          step_q <= div_quot;
        end
      end
      S_INTEG: isum_q <= use_int ? clamp_sym(PROD_W'(int_acc), int_limit_q) : '0;
      S_TOTAL: begin
        total_q <= SUM_W'(PROD_W'(pterm_q) + PROD_W'(isum_q) + PROD_W'(dterm_q));
      end
      default: ;
    endcase
  end

  mpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (prod_mag[PROD_W-2:0]),
    .divisor_i  (den[DATA_W-1:0]),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

### rtl/core/mpid_div.sv
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring divider, one quotient bit per cycle. The dividend is a
// magnitude whose quotient is known to fit 32 bits; sign is applied at the end.
// ----------------------------------------------------------------------------
module mpid_div import mpid_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  div_req_t                 req_i,
  input  logic [PROD_W-2:0]        dividend_i,
  input  logic [DATA_W-1:0]        divisor_i,
  output div_stat_t                stat_o,
  output logic signed [DATA_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    den_q, den_d;
  logic                 neg_q, neg_d;

  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !trial[DATA_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // upper dividend bits are already below the divisor
      rem_d  = {1'b0, dividend_i[PROD_W-2:DATA_W]};
      quo_d  = dividend_i[DATA_W-1:0];
      den_d  = divisor_i;
      neg_d  = req_i.negate;
    end else if (busy_q) begin
      rem_d = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### rtl/core/mpid_checker.sv
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the top-level ports for sequencing and result behavior.
// ----------------------------------------------------------------------------
`include "multimode_pid_controller_assert.svh"

module mpid_checker import mpid_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     operation_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] drive_o
);

  logic in_acc;
  logic clr_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign clr_acc   = in_acc && operation_i == OP_CLEAR && !out_valid_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // one item in flight: ready drops right after an accept
  `MPID_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_o, "ready held after accept")

  // a clear into an empty output posts a zero drive once the sequencer has moved to its result state
  `MPID_ASSERT_IMP(a_clear_zero, clr_acc, ##2 (out_valid_o && drive_o == '0), "clear not zero")

  // hold a stalled result
  `MPID_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(drive_o), "stalled drive changed")

  // drive only moves when a new result is posted
  `MPID_ASSERT_NXT(a_drive_quiet, !out_valid_o, $stable(drive_o) || out_valid_o, "drive moved early")

endmodule

bind multimode_pid_controller mpid_checker u_mpid_checker (.*);

### test/tb_multimode_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multimode PID controller testbench
// Feeds control steps and clears through the valid/ready input, predicts each
// drive value in fixed point alongside the block, and compares results in
// order. Loop mode, gains, limits and the integral scale are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_multimode_pid_controller;
  import mpid_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_THREE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam longint Q_SCALE     = longint'(1) << FRAC_BITS_DEF;
  localparam longint SEP_BAND_L  = 300 * Q_SCALE;
  localparam longint WRAP_HALF_L = 4096 * Q_SCALE;
  localparam longint WRAP_SPAN_L = 8192 * Q_SCALE;
  localparam longint WORD_MAX_L  = 64'sd2147483647;
  localparam longint WORD_MIN_L  = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_ONE     = DATA_W'(Q_SCALE);
  localparam logic signed [DATA_W-1:0] SEP_BAND  = DATA_W'(SEP_BAND_L);
  localparam logic signed [DATA_W-1:0] WRAP_HALF = DATA_W'(WRAP_HALF_L);
  localparam logic signed [DATA_W-1:0] WRAP_SPAN = DATA_W'(WRAP_SPAN_L);
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 3000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 153;

  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } pid_item_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [DATA_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic                     operation_i = OP_STEP;
  logic signed [DATA_W-1:0] target_i    = '0;
  logic signed [DATA_W-1:0] measured_i  = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] drive_o;

  multimode_pid_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Controller state and register copies
  logic [MODE_W-1:0] mdl_mode    = MODE_SEP;
  longint            mdl_kp      = 0;
  longint            mdl_ki      = 0;
  longint            mdl_kd      = 0;
  longint            mdl_out_lim = 0;
  longint            mdl_int_lim = 0;
  longint            mdl_scale   = longint'(VARY_SCALE_RST);
  longint            mdl_last_err = 0;
  longint            mdl_isum    = 0;

  pid_item_t                pending[$];
  logic signed [DATA_W-1:0] drive_expected[$];
  logic signed [DATA_W-1:0] drive_want;
  logic in_took   = 1'b0;
  logic out_took  = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int in_idle_max  = 3;
  int out_idle_max = 3;
  int in_gap       = 0;
  int rx_wait      = 0;
  int stuck_cycles = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int items_taken  = 0;
  int clears_taken = 0;
  int settings_run = 0;

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX_L) return WORD_MAX_L;
    if (v < WORD_MIN_L) return WORD_MIN_L;
    return v;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Full product, floor shift, then saturate
  function automatic longint q_mul(input longint a, input longint b);
    return sat_word((a * b) >>> FRAC_BITS_DEF);
  endfunction

  function automatic logic signed [DATA_W-1:0] predict_drive(
      input logic op, input logic signed [DATA_W-1:0] tgt,
      input logic signed [DATA_W-1:0] meas);
    longint e, ae, p_term, d_term, i_step, i_acc, den, total;
    if (op == OP_CLEAR) begin
      mdl_last_err = 0;
      mdl_isum = 0;
      return '0;
    end
    e = sat_word(longint'(tgt) - longint'(meas));
    if (mdl_mode == MODE_WRAP) begin
      if (e > WRAP_HALF_L) e = e - WRAP_SPAN_L;
      else if (e < -WRAP_HALF_L) e = e + WRAP_SPAN_L;
      e = sat_word(e);
    end
    ae = (e < 0) ? -e : e;
    p_term = q_mul(mdl_kp, e);
    if (mdl_mode == MODE_VARY) begin
      i_step = q_mul(mdl_ki, e);
      den = mdl_scale + ae;
      i_step = (den == 0) ? 0 : (i_step * mdl_scale) / den;
      i_acc = clamp_to(sat_word(mdl_isum + i_step), mdl_int_lim);
    end else if (ae < SEP_BAND_L) begin
      i_acc = clamp_to(sat_word(mdl_isum + q_mul(mdl_ki, e)), mdl_int_lim);
    end else begin
      // large error: drop the integral
      i_acc = 0;
    end
    d_term = q_mul(mdl_kd, sat_word(e - mdl_last_err));
    total = clamp_to(p_term + i_acc + d_term, mdl_out_lim);
    mdl_isum = i_acc;
    mdl_last_err = e;
    return total[DATA_W-1:0];
  endfunction

  function automatic pid_item_t rand_item();
    pid_item_t it;
    logic signed [DATA_W-1:0] err;
    it.op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_STEP;
    if ($urandom_range(0, 1) == 0) it.measured = $urandom;
    else it.measured = $urandom_range(0, 1 << 22) - (1 << 21);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: err = $urandom_range(0, 2 * SEP_BAND) - SEP_BAND;
      4, 5:       err = $urandom_range(0, 2 * WRAP_SPAN) - WRAP_SPAN;
      6: begin
        case ($urandom_range(0, 5))
          0: err = SEP_BAND;
          1: err = SEP_BAND - 1;
          2: err = -SEP_BAND;
          3: err = WRAP_HALF;
          4: err = WRAP_HALF + 1;
          default: err = -WRAP_HALF - 1;
        endcase
      end
      default: err = $urandom;
    endcase
    it.target = it.measured + err;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom;
      default: return $urandom_range(0, 16 << FRAC_BITS_DEF) - (8 << FRAC_BITS_DEF);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return $urandom;
      default: return $urandom_range(1, 4000) << FRAC_BITS_DEF;
    endcase
  endfunction

  task automatic add_item(input logic op, input logic signed [DATA_W-1:0] tgt,
                          input logic signed [DATA_W-1:0] meas);
    pid_item_t it;
    it.op = op;
    it.target = tgt;
    it.measured = meas;
    pending.push_back(it);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LOOP_MODE:  mdl_mode    = val[MODE_W-1:0];
      REG_GAIN_P:     mdl_kp      = longint'($signed(val));
      REG_GAIN_I:     mdl_ki      = longint'($signed(val));
      REG_GAIN_D:     mdl_kd      = longint'($signed(val));
      REG_OUT_LIMIT:  mdl_out_lim = longint'(val[LIM_W-1:0]);
      REG_INT_LIMIT:  mdl_int_lim = longint'(val[LIM_W-1:0]);
      REG_VARY_SCALE: mdl_scale   = longint'(val[LIM_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every item is taken and every drive has come back
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || drive_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending.size() != 0) begin
        pid_item_t it;
        it = pending.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= it.op;
        target_i    <= it.target;
        measured_i  <= it.measured;
        in_gap = $urandom_range(0, in_idle_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        rx_wait = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (out_took) begin
        rx_wait = $urandom_range(0, out_idle_max);
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Predict on every accepted item
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && in_ready_o;
    if (in_took) begin
      drive_expected.push_back(predict_drive(operation_i, target_i, measured_i));
      items_taken++;
      if (operation_i == OP_CLEAR) clears_taken++;
    end
  end

  // Compare every accepted drive with the oldest prediction
  always @(posedge clk_i) begin
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (out_took) begin
      if (drive_expected.size() == 0) begin
        $error("drive: expected nothing, got %0d", drive_o);
        mismatches++;
      end else begin
        drive_want = drive_expected.pop_front();
        results_seen++;
        if (drive_o !== drive_want) begin
          $error("drive: expected %0d, got %0d", drive_want, drive_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [MODE_W-1:0] mode_pick;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at reset values: zero gains and limits
    add_item(OP_STEP, 1000 * Q_ONE, '0);
    add_item(OP_STEP, 5 * Q_ONE, 3 * Q_ONE);
    wait_idle();

    set_reg(REG_LOOP_MODE, {{(DATA_W-MODE_W){1'b1}}, MODE_SEP});
    set_reg(REG_GAIN_P, Q_ONE);
    set_reg(REG_GAIN_I, Q_ONE / 2);
    set_reg(REG_GAIN_D, 2 * Q_ONE);
    set_reg(REG_OUT_LIMIT, '1);
    set_reg(REG_INT_LIMIT, '1);
    set_reg(REG_UNUSED, '0);
    settings_run++;
    add_item(OP_STEP, Q_MAX, Q_MIN);
    add_item(OP_STEP, Q_MIN, Q_MAX);
    add_item(OP_STEP, SEP_BAND - 1, '0);
    add_item(OP_STEP, SEP_BAND, '0);
    add_item(OP_STEP, -(SEP_BAND - 1), '0);
    add_item(OP_CLEAR, Q_MAX, Q_MAX);
    add_item(OP_STEP, '0, '0);
    wait_idle();

    set_reg(REG_LOOP_MODE, MODE_WRAP);
    settings_run++;
    add_item(OP_STEP, WRAP_HALF + 1, '0);
    add_item(OP_STEP, '0, WRAP_HALF + 1);
    add_item(OP_STEP, WRAP_HALF, '0);
    add_item(OP_STEP, Q_MAX, '0);
    wait_idle();

    // Zero scale in variable-speed mode
    set_reg(REG_LOOP_MODE, MODE_VARY);
    set_reg(REG_VARY_SCALE, '0);
    settings_run++;
    add_item(OP_STEP, '0, '0);
    add_item(OP_STEP, 5 * Q_ONE, '0);
    add_item(OP_STEP, Q_MIN, '0);
    wait_idle();

    set_reg(REG_LOOP_MODE, MODE_THREE);
    set_reg(REG_GAIN_P, Q_MAX);
    set_reg(REG_GAIN_I, Q_MIN);
    set_reg(REG_GAIN_D, Q_MAX);
    set_reg(REG_INT_LIMIT, 100 * Q_ONE);
    set_reg(REG_VARY_SCALE, VARY_SCALE_RST);
    settings_run++;
    add_item(OP_STEP, Q_MAX, Q_MIN);
    add_item(OP_STEP, Q_MIN, Q_MAX);
    add_item(OP_STEP, 32'sd100, '0);
    add_item(OP_CLEAR, Q_MIN, Q_MIN);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      in_idle_max  = (ph % 3 == 1) ? 0 : 3;
      out_idle_max = (ph % 3 == 2) ? 0 : 3;
      case (ph % 4)
        0: mode_pick = MODE_SEP;
        1: mode_pick = MODE_VARY;
        2: mode_pick = MODE_WRAP;
        default: mode_pick = MODE_THREE;
      endcase
      set_reg(REG_LOOP_MODE, {(DATA_W-MODE_W)'($urandom), mode_pick});
      set_reg(REG_GAIN_P, rand_gain());
      set_reg(REG_GAIN_I, rand_gain());
      set_reg(REG_GAIN_D, rand_gain());
      set_reg(REG_OUT_LIMIT, rand_limit());
      set_reg(REG_INT_LIMIT, rand_limit());
      set_reg(REG_VARY_SCALE, rand_limit());
      settings_run++;
      repeat (PHASE_ITEMS) pending.push_back(rand_item());
      // stall the receiver while the sender keeps offering items
      if (ph == 4) hold_req = 1'b1;
      wait_idle();
    end

    $display("Checked %0d drive results from %0d items (%0d clears) under %0d settings,",
             results_seen, items_taken, clears_taken, settings_run);
    $display("covering all loop modes, saturation, wrap and separation edges.");
    if (mismatches == 0 && drive_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
